>>> hw/rtl/rdsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsf_pkg: shared types, constants and helpers
// Widths, radix limits and ASCII mapping for the radix digit string formatter.
// ----------------------------------------------------------------------------
package rdsf_pkg;

  // Operand and digit store geometry
  localparam int VALUE_BITS = 63;
  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int BITCNT_W   = $clog2(VALUE_BITS);

  // Radix register and digit widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);

  // ASCII anchors
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Clamp the programmed radix into 2..36
  function automatic radix_t effective_radix(input radix_t r);
    radix_t res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Digit value to '0'..'9', 'A'..'Z'
  function automatic char_t digit_to_ascii(input digit_t d);
    char_t c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/radix_digit_string_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_string_formatter_core: integer to ASCII digits in radix 2..36
// Bit-serial repeated division fills a digit store, which is then read back
// most significant digit first.
// ----------------------------------------------------------------------------
// One value is converted at a time; value_stall stays high from the accepted
// transfer until the final digit has been taken. Each digit costs one pass of
// a shared bit-serial divider: a shift/compare/subtract step for each value
// bit, then a store of the remainder. Readout reads each digit from the store,
// then presents it, and holds it for as long as digit_stall is high. A 63-bit
// value gives at most 63 digits, in radix 2; zero gives one digit '0'.
// The radix register (reset 16) is to be written through the radix channel
// only while the block is idle; the block itself does not enforce this.
// Values below 2 act as 2 and above 36 act as 36.
// ----------------------------------------------------------------------------
module radix_digit_string_formatter_core (
  input  logic                           clk,
  input  logic                           rst,
  // radix configuration channel
  input  logic                           radix_valid,
  output logic                           radix_ready,
  input  logic [rdsf_pkg::RADIX_W-1:0]   radix,
  // input value channel
  input  logic                           value_valid,
  output logic                           value_stall,
  input  logic [rdsf_pkg::VALUE_BITS-1:0] value,
  // output digit channel
  output logic                           digit_valid,
  input  logic                           digit_stall,
  output logic [rdsf_pkg::CHAR_W-1:0]    digit_char,
  output logic                           last_digit
);
  import rdsf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [BITCNT_W-1:0] LAST_BIT  = BITCNT_W'(VALUE_BITS - 1);
  localparam logic [COUNT_W-1:0]  COUNT_MAX = COUNT_W'(MAX_DIGITS);

  logic [2:0]            state;
  radix_t                radix_reg;
  radix_t                divisor;
  logic [VALUE_BITS-1:0] work;
  digit_t                rem;
  logic [BITCNT_W-1:0]   bitcnt;
  logic [COUNT_W-1:0]    count;
  logic [ADDR_W-1:0]     rd_idx;
  digit_t                rd_data;

  digit_t                store_mem [MAX_DIGITS];

  logic                  in_xfer;
  logic                  out_xfer;
  logic [RADIX_W:0]      partial;
  logic                  q_bit;
  digit_t                rem_next;
  logic                  room;
  logic [COUNT_W-1:0]    count_next;

  assign in_xfer  = value_valid && !value_stall;
  assign out_xfer = digit_valid && !digit_stall;

  // Handshake outputs
  assign radix_ready = 1'b1;
  assign value_stall = (state != ST_IDLE);
  assign digit_valid = (state == ST_EMIT);
  assign digit_char  = digit_to_ascii(rd_data);
  assign last_digit  = (rd_idx == '0);

  // Shared divider step: bring in next dividend bit, trial subtract
  always_comb begin
    partial  = {rem, work[VALUE_BITS-1]};
    q_bit    = (partial >= {1'b0, divisor});
    rem_next = q_bit ? DIGIT_W'(partial - {1'b0, divisor}) : DIGIT_W'(partial);
  end

  // Digit count after storing the current remainder
  assign room       = (count < COUNT_MAX);
  assign count_next = room ? count + COUNT_W'(1) : count;

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RADIX_RESET;
    end else if (radix_valid && radix_ready) begin
      radix_reg <= radix;
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      bitcnt <= '0;
      work   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            work    <= value;
            divisor <= effective_radix(radix_reg);
            rem     <= '0;
            bitcnt  <= '0;
            count   <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          work   <= {work[VALUE_BITS-2:0], q_bit};
          rem    <= rem_next;
          bitcnt <= bitcnt + BITCNT_W'(1);
          if (bitcnt == LAST_BIT) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          count  <= count_next;
          rem    <= '0;
          bitcnt <= '0;
          if (work == '0) begin
            rd_idx <= ADDR_W'(count_next - COUNT_W'(1));
            state  <= ST_READ;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            if (rd_idx == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx - ADDR_W'(1);
              state  <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit store: written after each division, read back during readout
  always_ff @(posedge clk) begin
    if (state == ST_STORE && room) begin
      store_mem[count[ADDR_W-1:0]] <= rem;
    end
    if (state == ST_READ) begin
      rd_data <= store_mem[rd_idx];
    end
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !value_stall |-> !digit_valid)
    else $error("digit presented while idle");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_DIV && count == '0))
    else $error("accepted value did not start division");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < divisor)
    else $error("partial remainder not below radix");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_digit) |=> !digit_valid && !value_stall)
    else $error("block not idle after final digit");

  a_divisor_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> (divisor >= RADIX_MIN && divisor <= RADIX_MAX))
    else $error("divisor outside radix range");

endmodule
